FILE: src/itp_pkg.sv
`default_nettype none
package itp_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_END
  } sym_cls_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_INPUT,
    EM_TOP,
    EM_DONE
  } emit_sel_e;

  typedef struct packed {
    logic      in_ready;
    logic      accept;
    emit_sel_e emit_sel;
    logic      push;
    logic      push_in;
    logic      pop;
    logic      rd_en;
    logic      set_unmatched;
    logic      clear_flags;
  } itp_cmd_t;

  typedef struct packed {
    logic     in_valid;
    sym_cls_e in_cls;
    sym_cls_e lat_cls;
    logic     count_zero;
    logic     out_free;
    logic     top_is_open;
    logic     top_prec_ge;
  } itp_status_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic sym_cls_e classify(input logic [7:0] c, input logic eoe);
    sym_cls_e k;
    k = CLS_OTHER;
    if (eoe) k = CLS_END;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39)) k = CLS_ALNUM;
    else if (c == CH_LPAREN) k = CLS_OPEN;
    else if (c == CH_RPAREN) k = CLS_CLOSE;
    else if (prec_of(c) != 2'd0) k = CLS_OP;
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: src/infix_to_postfix_converter.sv
// Letters, digits, '(' and ignored characters: only a letter or digit gives a
// result, through the registered output. ')', operators and end of expression:
// accepted, then per stack entry examined a memory read, then a decision (set by
// the single stack read port), and a last ST_FETCH step when the stack runs empty.
// End of expression adds the done result; output stalls hold the flow.
// Reset (asynchronous, active low) empties the stack and clears both flags.
`default_nettype none
module infix_to_postfix_converter (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  wire  [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  wire        s_axis_tuser_i,   // [0] end_of_expr
  output logic       m_axis_tvalid_o,
  input  wire        m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] token
  output logic       m_axis_tlast_o,   // done_res
  output logic [1:0] m_axis_tuser_o    // [0] overflow_seen, [1] unmatched_close
);
  import itp_pkg::*;

  itp_cmd_t    cmd;
  itp_status_t status;

  itp_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  itp_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tready_i (m_axis_tready_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

endmodule
`default_nettype wire

FILE: src/itp_datapath.sv
`default_nettype none
module itp_datapath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_tvalid_i,
  input  wire  [7:0]           s_tdata_i,   // symbol
  input  wire                  s_tuser_i,   // end_of_expr
  input  wire                  m_tready_i,
  input  itp_pkg::itp_cmd_t    cmd_i,
  output itp_pkg::itp_status_t status_o,
  output logic                 m_tvalid_o,
  output logic [7:0]           m_tdata_o,   // token
  output logic                 m_tlast_o,   // done_res
  output logic [1:0]           m_tuser_o    // overflow_seen, unmatched_close
);
  import itp_pkg::*;

  logic [7:0]       op_stack_q [STACK_DEPTH];
  logic [7:0]       rd_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             unm_q, unm_d;
  logic [7:0]       sym_q;
  sym_cls_e         cls_q;
  logic             m_valid_q;
  logic [7:0]       m_data_q;
  logic             m_last_q;
  logic [1:0]       m_user_q;

  logic [CNT_W-1:0] count_m1;
  logic             full;
  logic             out_free;
  logic [7:0]       push_val;
  logic             do_write;

  assign count_m1 = count_q - CNT_W'(1);
  assign full     = (count_q == CNT_W'(STACK_DEPTH));
  assign out_free = !m_valid_q || m_tready_i;
  assign push_val = cmd_i.push_in ? s_tdata_i : sym_q;
  assign do_write = cmd_i.push && !full;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    unm_d   = unm_q;
    if (cmd_i.push) begin
      if (full) ovf_d = 1'b1;
      else count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.pop) count_d = count_m1;
    if (cmd_i.set_unmatched) unm_d = 1'b1;
    if (cmd_i.clear_flags) begin
      ovf_d = 1'b0;
      unm_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) op_stack_q[count_q[PTR_W-1:0]] <= push_val;
    if (cmd_i.rd_en) rd_q <= op_stack_q[count_m1[PTR_W-1:0]];
    if (cmd_i.accept) begin
      sym_q <= s_tdata_i;
      cls_q <= classify(s_tdata_i, s_tuser_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      unm_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      unm_q   <= unm_d;
      if (cmd_i.emit_sel != EM_NONE) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.emit_sel)
      EM_INPUT: begin
        m_data_q <= s_tdata_i;
        m_last_q <= 1'b0;
        m_user_q <= {unm_q, ovf_q};
      end
      EM_TOP: begin
        m_data_q <= rd_q;
        m_last_q <= 1'b0;
        m_user_q <= {unm_q, ovf_q};
      end
      EM_DONE: begin
        m_data_q <= CH_NUL;
        m_last_q <= 1'b1;
        m_user_q <= {unm_q, ovf_q};
      end
      default: begin
      end
    endcase
  end

  assign status_o.in_valid    = s_tvalid_i;
  assign status_o.in_cls      = classify(s_tdata_i, s_tuser_i);
  assign status_o.lat_cls     = cls_q;
  assign status_o.count_zero  = (count_q == '0);
  assign status_o.out_free    = out_free;
  assign status_o.top_is_open = (rd_q == CH_LPAREN);
  assign status_o.top_prec_ge = (prec_of(rd_q) >= prec_of(sym_q));

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;
  assign m_tuser_o  = m_user_q;

endmodule
`default_nettype wire

FILE: src/itp_controller.sv
`default_nettype none
module itp_controller (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  itp_pkg::itp_status_t status_i,
  output itp_pkg::itp_cmd_t    cmd_o
);
  import itp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_DONE
  } state_e;

  state_e   state_q, state_d;
  itp_cmd_t cmd;

  always_comb begin
    cmd               = '0;
    cmd.emit_sel      = EM_NONE;
    state_d           = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd.in_ready = status_i.out_free;
        cmd.accept   = status_i.out_free && status_i.in_valid;
        if (cmd.accept) begin
          unique case (status_i.in_cls)
            CLS_ALNUM: cmd.emit_sel = EM_INPUT;
            CLS_OPEN: begin
              cmd.push    = 1'b1;
              cmd.push_in = 1'b1;
            end
            CLS_CLOSE, CLS_OP, CLS_END: state_d = ST_FETCH;
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (status_i.count_zero) begin
          priority case (status_i.lat_cls)
            CLS_CLOSE: begin
              cmd.set_unmatched = 1'b1;
              state_d           = ST_IDLE;
            end
            CLS_OP: begin
              cmd.push = 1'b1;
              state_d  = ST_IDLE;
            end
            default: state_d = ST_DONE;
          endcase
        end else begin
          cmd.rd_en = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.lat_cls == CLS_CLOSE && status_i.top_is_open) begin
          cmd.pop = 1'b1;
          state_d = ST_IDLE;
        end else if (status_i.lat_cls == CLS_OP && !status_i.top_prec_ge) begin
          cmd.push = 1'b1;
          state_d  = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd.emit_sel = EM_TOP;
          cmd.pop      = 1'b1;
          state_d      = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd.emit_sel    = EM_DONE;
          cmd.clear_flags = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule
`default_nettype wire

FILE: src/itp_checker.sv
`default_nettype none
module itp_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       s_axis_tvalid_i,
  input wire       s_axis_tready_o,
  input wire [7:0] s_axis_tdata_i,
  input wire       s_axis_tuser_i,
  input wire       m_axis_tvalid_o,
  input wire       m_axis_tready_i,
  input wire [7:0] m_axis_tdata_o,
  input wire       m_axis_tlast_o,
  input wire [1:0] m_axis_tuser_o
);

  logic in_alnum;
  assign in_alnum = (s_axis_tdata_i >= 8'h61 && s_axis_tdata_i <= 8'h7A) ||
                    (s_axis_tdata_i >= 8'h41 && s_axis_tdata_i <= 8'h5A) ||
                    (s_axis_tdata_i >= 8'h30 && s_axis_tdata_i <= 8'h39);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  a_done_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o == 8'h00)
    else $error("done result carries a token");

  a_alnum_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i && in_alnum |=>
      m_axis_tvalid_o && !m_axis_tlast_o && m_axis_tdata_o == $past(s_axis_tdata_i))
    else $error("operand not passed straight through");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> !s_axis_tready_o)
    else $error("request taken during flush");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

FILE: dv/tb_infix_to_postfix_converter.sv
`timescale 1ns / 100ps
module tb_infix_to_postfix_converter;
  import itp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4 * STACK_DEPTH + 32;

  typedef struct packed {
    logic [7:0] token;
    logic       done;
    logic       ovf;
    logic       unm;
  } postfix_tok_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tuser  = 1'b0;
  logic       m_tready = 1'b0;

  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;

  infix_to_postfix_converter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),          // [7:0] symbol
    .s_axis_tuser_i (s_tuser),          // [0] end_of_expr
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),   // [7:0] token
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)    // [0] overflow_seen, [1] unmatched_close
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]   opstk [STACK_DEPTH];
  int           stk_cnt  = 0;
  bit           ovf_flag = 1'b0;
  bit           unm_flag = 1'b0;
  postfix_tok_t postfix_q [$];

  int n_fail       = 0;
  int n_sent       = 0;
  int idle_cycles  = 0;
  int stall_left   = 0;
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;

  function automatic logic [1:0] rank_of(logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS: return 2'd1;
      CH_STAR, CH_SLASH: return 2'd2;
      CH_CARET:          return 2'd3;
      default:           return 2'd0;
    endcase
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  task automatic emit_token(logic [7:0] t, logic d);
    postfix_q.push_back('{t, d, ovf_flag, unm_flag});
  endtask

  task automatic push_stack(logic [7:0] c);
    if (stk_cnt >= STACK_DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      opstk[stk_cnt] = c;
      stk_cnt++;
    end
  endtask

  task automatic convert_symbol(logic [7:0] c, logic eoe);
    logic [1:0] p;
    if (eoe) begin
      while (stk_cnt > 0) begin
        stk_cnt--;
        emit_token(opstk[stk_cnt], 1'b0);
      end
      emit_token(CH_NUL, 1'b1);
      ovf_flag = 1'b0;
      unm_flag = 1'b0;
    end else if (is_alnum(c)) begin
      emit_token(c, 1'b0);
    end else if (c == CH_LPAREN) begin
      push_stack(c);
    end else if (c == CH_RPAREN) begin
      while (stk_cnt > 0 && opstk[stk_cnt - 1] != CH_LPAREN) begin
        stk_cnt--;
        emit_token(opstk[stk_cnt], 1'b0);
      end
      if (stk_cnt > 0) stk_cnt--;
      else unm_flag = 1'b1;
    end else if (rank_of(c) != 2'd0) begin
      p = rank_of(c);
      while (stk_cnt > 0 && rank_of(opstk[stk_cnt - 1]) >= p) begin
        stk_cnt--;
        emit_token(opstk[stk_cnt], 1'b0);
      end
      push_stack(c);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    postfix_tok_t want;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_tvalid && s_axis_tready_o) begin
        convert_symbol(s_tdata, s_tuser);
        moved = 1'b1;
      end
      if (m_axis_tvalid_o && m_tready) begin
        moved = 1'b1;
        if (postfix_q.size() == 0) begin
          $error("unexpected result: token %h last %b user %b",
                 m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
          n_fail++;
        end else begin
          want = postfix_q.pop_front();
          if (m_axis_tdata_o !== want.token) begin
            $error("token: expected %h, got %h", want.token, m_axis_tdata_o);
            n_fail++;
          end
          if (m_axis_tlast_o !== want.done) begin
            $error("done_res: expected %b, got %b", want.done, m_axis_tlast_o);
            n_fail++;
          end
          if (m_axis_tuser_o[0] !== want.ovf) begin
            $error("overflow_seen: expected %b, got %b", want.ovf, m_axis_tuser_o[0]);
            n_fail++;
          end
          if (m_axis_tuser_o[1] !== want.unm) begin
            $error("unmatched_close: expected %b, got %b", want.unm, m_axis_tuser_o[1]);
            n_fail++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_infix_to_postfix_converter failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin : sink_stall
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(logic [7:0] sym, logic eoe);
    int gap;
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tuser  <= eoe;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic idle_bus();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (postfix_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'h61 + 8'($urandom_range(0, 25));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] rand_noise();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return CH_RPAREN;
      2:       return rand_operator();
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic send_expression(int n_operands, int noise_pct);
    int depth;
    depth = 0;
    for (int k = 0; k < n_operands; k++) begin
      while ($urandom_range(0, 3) == 0) begin
        send_item(CH_LPAREN, 1'b0);
        depth++;
      end
      send_item(rand_operand(), 1'b0);
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        send_item(CH_RPAREN, 1'b0);
        depth--;
      end
      if (noise_pct > $urandom_range(0, 99)) send_item(rand_noise(), 1'b0);
      if (k != n_operands - 1) send_item(rand_operator(), 1'b0);
    end
    while (depth > 0 && $urandom_range(0, 5) != 0) begin
      send_item(CH_RPAREN, 1'b0);
      depth--;
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_directed_symbols();
    send_item(CH_NUL, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h40, 1'b0);
    send_item(CH_LPAREN, 1'b0);
    send_item("A", 1'b0);
    send_item(CH_PLUS, 1'b0);
    send_item("z", 1'b0);
    send_item(CH_RPAREN, 1'b0);
    send_item(CH_STAR, 1'b0);
    send_item("0", 1'b0);
    send_item(CH_CARET, 1'b0);
    send_item("9", 1'b0);
    send_item(CH_CARET, 1'b0);
    send_item("Z", 1'b0);
    send_item(CH_MINUS, 1'b0);
    send_item(CH_SLASH, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(CH_RPAREN, 1'b0);
    send_item("a", 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(CH_LPAREN, 1'b0);
    send_item(CH_LPAREN, 1'b0);
    send_item("b", 1'b0);
    send_item(8'h5A, 1'b1);
    send_item(8'hA5, 1'b1);
  endtask

  task automatic test_stack_overflow();
    repeat (STACK_DEPTH + 6) begin
      send_item(CH_LPAREN, 1'b0);
      if ($urandom_range(0, 1) == 1) send_item(rand_operator(), 1'b0);
      if ($urandom_range(0, 2) == 0) send_item(rand_operand(), 1'b0);
    end
    repeat ($urandom_range(0, 4)) send_item(CH_RPAREN, 1'b0);
    send_item(rand_operator(), 1'b0);
    send_item(rand_operand(), 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_pause_until_drained();
    send_expression(6, 10);
    idle_bus();
    wait_drained();
    send_expression(4, 10);
  endtask

  task automatic test_random_expressions();
    while (n_sent < 230) send_expression($urandom_range(1, 8), 15);
  endtask

  task automatic test_flow_without_idling();
    int stop_at;
    stop_at      = n_sent + 50;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    while (n_sent < stop_at) send_expression($urandom_range(2, 6), 10);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_symbols();
    test_stack_overflow();
    test_pause_until_drained();
    test_random_expressions();
    test_stack_overflow();
    test_flow_without_idling();

    idle_bus();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (postfix_q.size() != 0) begin
      $error("%0d expected results never arrived", postfix_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("tb_infix_to_postfix_converter passed");
    end else begin
      $display("tb_infix_to_postfix_converter failed");
    end
    $finish;
  end

endmodule
